>>> src/lsc_pkg.sv
// Shared types, constants and helpers of the line segment clipper.
// No dependencies; every other file of the block imports this package.
package lsc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * COORD_BITS;
  localparam int CLIP_ROUNDS = 4;
  localparam int DIV_STAGES  = COORD_BITS;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_X_LOW  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_Y_LOW  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_X_HIGH = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_Y_HIGH = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic [PROD_BITS-1:0]         prod_t;
  typedef logic [3:0]                   code_t;

  typedef struct packed {
    coord_t x_low;
    coord_t y_low;
    coord_t x_high;
    coord_t y_high;
  } win_t;

  typedef struct packed {
    logic   fin;
    logic   acc;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    code_t  c1;
    code_t  c2;
  } seg_t;

  function automatic code_t region(coord_t x, coord_t y, win_t w);
    code_t c;
    c = '0;
    if (y > w.y_high) c = c | CODE_TOP;
    if (y < w.y_low)  c = c | CODE_BOTTOM;
    if (x < w.x_low)  c = c | CODE_LEFT;
    if (x > w.x_high) c = c | CODE_RIGHT;
    return c;
  endfunction

  // Differences of two coordinates never reach the negative end of diff_t.
  function automatic mag_t magnitude(diff_t v);
    diff_t n;
    n = v[DIFF_BITS-1] ? -v : v;
    return n[COORD_BITS-1:0];
  endfunction

endpackage

>>> src/lsc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on lsc_pkg. The quotient must fit in COORD_BITS bits.
module lsc_div (
  input  logic            clk,
  input  logic            en,
  input  lsc_pkg::prod_t  dividend,
  input  lsc_pkg::mag_t   divisor,
  output lsc_pkg::mag_t   quotient,
  output logic            rem_nz
);
  import lsc_pkg::*;

  mag_t rem_s [DIV_STAGES+1];
  mag_t low_s [DIV_STAGES+1];
  mag_t quo_s [DIV_STAGES+1];
  mag_t dvs_s [DIV_STAGES+1];

  assign rem_s[0] = dividend[PROD_BITS-1:COORD_BITS];
  assign low_s[0] = dividend[COORD_BITS-1:0];
  assign quo_s[0] = '0;
  assign dvs_s[0] = divisor;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [COORD_BITS:0] trial;
    logic [COORD_BITS:0] diff;
    logic                fits;

    assign trial = {rem_s[k], low_s[k][COORD_BITS-1]};
    assign diff  = trial - {1'b0, dvs_s[k]};
    assign fits  = trial >= {1'b0, dvs_s[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
        low_s[k+1] <= {low_s[k][COORD_BITS-2:0], 1'b0};
        quo_s[k+1] <= {quo_s[k][COORD_BITS-2:0], fits};
        dvs_s[k+1] <= dvs_s[k];
      end
    end
  end

  assign quotient = quo_s[DIV_STAGES];
  assign rem_nz   = rem_s[DIV_STAGES] != '0;

endmodule

>>> src/lsc_round.sv
// One clip round: resolve or pick an edge, multiply, divide, move the endpoint, recode.
// Depends on lsc_pkg and lsc_div.
module lsc_round (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  lsc_pkg::seg_t  in_seg,
  input  lsc_pkg::win_t  win,
  output logic           out_valid,
  output lsc_pkg::seg_t  out_seg
);
  import lsc_pkg::*;

  typedef struct packed {
    seg_t   seg;
    logic   mv1;
    logic   ytype;
    coord_t edge_pos;
    coord_t base;
  } ctx_t;

  typedef struct packed {
    ctx_t ctx;
    logic neg;
    logic dz;
  } side_t;

  // stage A: resolve and choose the edge
  seg_t   rs;
  code_t  pick;
  logic   ytype;
  coord_t edge_pos;
  coord_t base;
  diff_t  a_n, num_n, den_n;

  always_comb begin
    rs = in_seg;
    if (!rs.fin) begin
      if (rs.c1 == '0 && rs.c2 == '0) begin
        rs.fin = 1'b1;
        rs.acc = 1'b1;
      end else if ((rs.c1 & rs.c2) != '0) begin
        rs.fin = 1'b1;
        rs.acc = 1'b0;
      end
    end
    pick = (rs.c1 != '0) ? rs.c1 : rs.c2;
    if ((pick & CODE_TOP) != '0) begin
      ytype = 1'b1;
      edge_pos = win.y_high;
    end else if ((pick & CODE_BOTTOM) != '0) begin
      ytype = 1'b1;
      edge_pos = win.y_low;
    end else if ((pick & CODE_LEFT) != '0) begin
      ytype = 1'b0;
      edge_pos = win.x_low;
    end else begin
      ytype = 1'b0;
      edge_pos = win.x_high;
    end
    if (ytype) begin
      base  = rs.x1;
      a_n   = diff_t'(edge_pos) - diff_t'(rs.y1);
      num_n = diff_t'(rs.x2) - diff_t'(rs.x1);
      den_n = diff_t'(rs.y2) - diff_t'(rs.y1);
    end else begin
      base  = rs.y1;
      a_n   = diff_t'(edge_pos) - diff_t'(rs.x1);
      num_n = diff_t'(rs.y2) - diff_t'(rs.y1);
      den_n = diff_t'(rs.x2) - diff_t'(rs.x1);
    end
  end

  logic  va, vb, vc;
  ctx_t  ctx_a, ctx_b;
  diff_t a_a, num_a, den_a;
  mag_t  ua_b, un_b, ud_b, ud_c;
  logic  neg_b, dz_b;
  side_t side_c;
  prod_t prod_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_a <= '{seg: rs, mv1: (rs.c1 != '0), ytype: ytype, edge_pos: edge_pos, base: base};
      a_a   <= a_n;
      num_a <= num_n;
      den_a <= den_n;
      // stage B: magnitudes and sign
      ctx_b <= ctx_a;
      ua_b  <= magnitude(a_a);
      un_b  <= magnitude(num_a);
      ud_b  <= magnitude(den_a);
      neg_b <= a_a[DIFF_BITS-1] ^ num_a[DIFF_BITS-1] ^ den_a[DIFF_BITS-1];
      dz_b  <= den_a == '0;
      // stage C: product
      side_c <= '{ctx: ctx_b, neg: neg_b, dz: dz_b};
      prod_c <= ua_b * un_b;
      ud_c   <= ud_b;
    end
  end

  mag_t quo;
  logic rem_nz;

  lsc_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (prod_c),
    .divisor  (ud_c),
    .quotient (quo),
    .rem_nz   (rem_nz)
  );

  // side data travels beside the divider
  side_t side_d [DIV_STAGES];
  logic  vd     [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_c;
      for (int i = 1; i < DIV_STAGES; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        vd[i] <= 1'b0;
      end
    end else if (en) begin
      vd[0] <= vc;
      for (int i = 1; i < DIV_STAGES; i++) begin
        vd[i] <= vd[i-1];
      end
    end
  end

  // stage E: truncate toward zero and move the endpoint
  side_t                     sd;
  logic signed [DIFF_BITS:0] sum;
  coord_t                    t;
  seg_t                      seg_n;

  always_comb begin
    sd = side_d[DIV_STAGES-1];
    if (sd.neg) begin
      sum = (DIFF_BITS+1)'(sd.ctx.base) - $signed({2'b00, quo});
    end else begin
      sum = (DIFF_BITS+1)'(sd.ctx.base) + $signed({2'b00, quo});
    end
    if (rem_nz && !sd.neg && sum < 0) begin
      sum = sum + (DIFF_BITS+1)'(1);
    end else if (rem_nz && sd.neg && sum > 0) begin
      sum = sum - (DIFF_BITS+1)'(1);
    end
    t = sd.dz ? sd.ctx.base : sum[COORD_BITS-1:0];
    seg_n = sd.ctx.seg;
    if (!seg_n.fin) begin
      if (sd.ctx.mv1) begin
        seg_n.x1 = sd.ctx.ytype ? t : sd.ctx.edge_pos;
        seg_n.y1 = sd.ctx.ytype ? sd.ctx.edge_pos : t;
      end else begin
        seg_n.x2 = sd.ctx.ytype ? t : sd.ctx.edge_pos;
        seg_n.y2 = sd.ctx.ytype ? sd.ctx.edge_pos : t;
      end
    end
  end

  logic ve;
  seg_t seg_e;
  seg_t seg_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      ve <= vd[DIV_STAGES-1];
      out_valid <= ve;
    end
  end

  // stage F: recode the moved segment
  always_comb begin
    seg_f = seg_e;
    if (!seg_e.fin) begin
      seg_f.c1 = region(seg_e.x1, seg_e.y1, win);
      seg_f.c2 = region(seg_e.x2, seg_e.y2, win);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_e <= seg_n;
      out_seg <= seg_f;
    end
  end

`ifndef SYNTHESIS
  a_acc_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_seg.acc |-> out_seg.fin)
    else $error("accepted segment not marked resolved");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_valid) && $stable(out_seg))
    else $error("round output moved during stall");
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid && !va && !ve)
    else $error("valid bits survive reset");
`endif

endmodule

>>> src/line_segment_clipper.sv
// Line segment clipper against a programmable rectangular window. One segment
// enters per clock while the output is not stalled; results leave in order after
// four unrolled clip rounds, each with a one-bit-per-stage divider. All stages
// advance together and hold while a result waits. The window may be rewritten only
// when no segment is in flight. A rejected segment reports zero coordinates.
// Depends on lsc_pkg, lsc_round and lsc_div.
module line_segment_clipper (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [4*lsc_pkg::COORD_BITS-1:0]    s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // accepted, clip_start_x, clip_start_y, clip_end_x, clip_end_y, zero fill
  output logic [4*lsc_pkg::COORD_BITS+7:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lsc_pkg::COORD_BITS-1:0]      cfg_data
);
  import lsc_pkg::*;

  localparam int OUT_BITS = 4 * COORD_BITS + 8;

  win_t win;
  logic en;

  assign cfg_ready = 1'b1;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.x_low  <= '0;
      win.y_low  <= '0;
      win.x_high <= COORD_BITS'(639);
      win.y_high <= COORD_BITS'(479);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIN_X_LOW:  win.x_low  <= cfg_data;
        REG_WIN_Y_LOW:  win.y_low  <= cfg_data;
        REG_WIN_X_HIGH: win.x_high <= cfg_data;
        REG_WIN_Y_HIGH: win.y_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stage: register the segment with its region codes
  coord_t in_x1, in_y1, in_x2, in_y2;
  assign in_x1 = s_tdata[COORD_BITS-1:0];
  assign in_y1 = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_x2 = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign in_y2 = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

  logic rv [CLIP_ROUNDS+1];
  seg_t rseg [CLIP_ROUNDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (en) begin
      rv[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rseg[0] <= '{fin: 1'b0, acc: 1'b0, x1: in_x1, y1: in_y1, x2: in_x2, y2: in_y2,
                   c1: region(in_x1, in_y1, win), c2: region(in_x2, in_y2, win)};
    end
  end

  for (genvar r = 0; r < CLIP_ROUNDS; r++) begin : g_round
    lsc_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (rv[r]),
      .in_seg    (rseg[r]),
      .win       (win),
      .out_valid (rv[r+1]),
      .out_seg   (rseg[r+1])
    );
  end

  // final resolve: unresolved after the last round counts only if fully inside
  seg_t fs;
  logic facc;

  always_comb begin
    fs = rseg[CLIP_ROUNDS];
    facc = fs.fin ? fs.acc : (fs.c1 == '0 && fs.c2 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= rv[CLIP_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (facc) begin
        m_tdata <= {7'd0, fs.y2, fs.x2, fs.y1, fs.x1, 1'b1};
      end else begin
        m_tdata <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[OUT_BITS-1:1] == '0)
    else $error("rejected segment carries coordinates");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid && !rv[0])
    else $error("valid bits survive reset");
`endif

endmodule

>>> verif/tb.sv
// Self-checking testbench for line_segment_clipper: directed and random segments,
// window rewrites between phases, random idling on both streams.
// Depends on lsc_pkg and the line_segment_clipper RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsc_pkg::*;

  typedef struct packed {
    logic   acc;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_res_t;

  localparam int LATENCY = 4 * (COORD_BITS + 5) + 1;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [4*COORD_BITS-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [4*COORD_BITS+7:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0] cfg_data;

  line_segment_clipper u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the window
  longint wxl, wyl, wxh, wyh;
  clip_res_t clip_q[$];
  int errors;
  int mismatches;
  int hold_off;
  bit rx_idle_en;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb: FAIL");
    $finish;
  end

  function automatic bit [3:0] outcode(longint x, longint y);
    bit [3:0] c;
    c = '0;
    if (y > wyh) c |= CODE_TOP;
    if (y < wyl) c |= CODE_BOTTOM;
    if (x < wxl) c |= CODE_LEFT;
    if (x > wxh) c |= CODE_RIGHT;
    return c;
  endfunction

  // base + a*num/den, the whole sum truncated toward zero
  function automatic longint edge_cross(longint base, longint a, longint num, longint den);
    longint p, q, t;
    bit neg;
    if (den == 0) return base;
    p = a * num;
    q = p / den;
    t = base + q;
    neg = (p < 0) != (den < 0);
    if (p % den != 0) begin
      if (!neg && t < 0) t += 1;
      else if (neg && t > 0) t -= 1;
    end
    return t;
  endfunction

  function automatic clip_res_t clip_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint x1, y1, x2, y2, x, y;
    bit [3:0] c1, c2, pick;
    clip_res_t r;
    x1 = ax; y1 = ay; x2 = bx; y2 = by;
    c1 = outcode(x1, y1);
    c2 = outcode(x2, y2);
    r = '0;
    for (int rnd = 0; rnd <= CLIP_ROUNDS; rnd++) begin
      if (c1 == 0 && c2 == 0) begin
        r.acc = 1'b1;
        break;
      end
      if ((c1 & c2) != 0 || rnd == CLIP_ROUNDS) break;
      pick = (c1 != 0) ? c1 : c2;
      if (pick & CODE_TOP) begin
        y = wyh; x = edge_cross(x1, wyh - y1, x2 - x1, y2 - y1);
      end else if (pick & CODE_BOTTOM) begin
        y = wyl; x = edge_cross(x1, wyl - y1, x2 - x1, y2 - y1);
      end else if (pick & CODE_LEFT) begin
        x = wxl; y = edge_cross(y1, wxl - x1, y2 - y1, x2 - x1);
      end else begin
        x = wxh; y = edge_cross(y1, wxh - x1, y2 - y1, x2 - x1);
      end
      if (c1 != 0) begin
        x1 = x; y1 = y; c1 = outcode(x1, y1);
      end else begin
        x2 = x; y2 = y; c2 = outcode(x2, y2);
      end
    end
    if (r.acc) begin
      r.sx = coord_t'(x1); r.sy = coord_t'(y1);
      r.ex = coord_t'(x2); r.ey = coord_t'(y2);
    end
    return r;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      gap = rx_idle_en ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk iff m_tvalid);
    end
  end

  // result checker
  always @(posedge clk) begin
    clip_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.acc = m_tdata[0];
      got.sx  = m_tdata[COORD_BITS:1];
      got.sy  = m_tdata[2*COORD_BITS:COORD_BITS+1];
      got.ex  = m_tdata[3*COORD_BITS:2*COORD_BITS+1];
      got.ey  = m_tdata[4*COORD_BITS:3*COORD_BITS+1];
      if (clip_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", got);
      end else begin
        want = clip_q.pop_front();
        if (got !== want || m_tdata[4*COORD_BITS+7:4*COORD_BITS+1] !== '0) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp acc=%0d (%0d,%0d)-(%0d,%0d) got acc=%0d (%0d,%0d)-(%0d,%0d)",
                     want.acc, want.sx, want.sy, want.ex, want.ey,
                     got.acc, got.sx, got.sy, got.ex, got.ey);
        end
      end
    end
  end

  // valid stays up after a transfer; drain() drops it
  task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {by, bx, ay, ax};
    @(posedge clk iff s_tready);
    clip_q.push_back(clip_segment(ax, ay, bx, by));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (clip_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, coord_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    case (idx)
      REG_WIN_X_LOW:  wxl = val;
      REG_WIN_Y_LOW:  wyl = val;
      REG_WIN_X_HIGH: wxh = val;
      default:        wyh = val;
    endcase
  endtask

  task automatic set_window(coord_t xl, coord_t yl, coord_t xh, coord_t yh);
    write_reg(REG_WIN_X_LOW, xl);
    write_reg(REG_WIN_Y_LOW, yl);
    write_reg(REG_WIN_X_HIGH, xh);
    write_reg(REG_WIN_Y_HIGH, yh);
    cfg_valid <= 1'b0;
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'(int'($urandom_range(0, 1400)) - 380);
      default: return coord_t'(int'($urandom_range(0, 120)) - 60);
    endcase
  endfunction

  task automatic test_directed();
    coord_t mx, mn;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    send_segment(10, 10, 600, 400, 0);
    send_segment(-5, 100, 700, 100, 0);
    send_segment(100, -50, 100, 600, 0);
    send_segment(-100, -100, -10, -20, 0);
    send_segment(700, 500, 900, 600, 0);
    send_segment(mn, mn, mx, mx, 0);
    send_segment(mx, mn, mn, mx, 0);
    send_segment(mn, 240, mx, 240, 0);
    send_segment(-200, 0, 0, 500, 0);
    send_segment(0, 0, 639, 479, 0);
    send_segment(-1, -1, 640, 480, 0);
    send_segment(320, 240, 320, 240, 0);
    send_segment(mx, mx, mx, mx, 0);
    send_segment(-50, 300, 300, -50, 0);
    send_segment(700, 100, 100, 700, 0);
    drain();
    // inverted window: both bits of a pair can be set
    set_window(100, 100, -100, -100);
    send_segment(0, 0, 5, 5, 0);
    send_segment(-300, 50, 300, -50, 0);
    send_segment(mn, mn, mx, mx, 0);
    drain();
    set_window(mn, mn, mx, mx);
    send_segment(mn, mx, mx, mn, 0);
    send_segment(0, 0, 1, 1, 0);
    drain();
    set_window(0, 0, 0, 0);
    send_segment(-3, -7, 5, 11, 0);
    send_segment(-1, 0, 1, 0, 0);
    drain();
  endtask

  task automatic test_random(int count, int mode);
    for (int i = 0; i < count; i++) begin
      rx_idle_en = (i % 200) < 150;
      send_segment(rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
                   (i % 300) < 220);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 150; i++)
      send_segment(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1), 0);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    mismatches = 0;
    hold_off = 0;
    rx_idle_en = 1'b1;
    wxl = 0; wyl = 0; wxh = 639; wyh = 479;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_window(0, 0, 639, 479);
    test_random(500, 1);
    test_backpressure();
    set_window(-40, -30, 40, 30);
    test_random(450, 2);
    test_random(200, 0);
    set_window(coord_t'($urandom()), coord_t'($urandom()),
               coord_t'($urandom()), coord_t'($urandom()));
    test_random(300, 0);
    set_window(-32768, -20, 32767, 20);
    test_random(300, 0);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
